// File: rtl/core/ffha_pkg.sv
`default_nettype none
package ffha_pkg;
   localparam int KIND_W = 2;
   localparam int SIZE_W = 21;
   localparam int ADDR_W = 20;
   localparam int STAT_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_REALLOC = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE    = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_BADADDR = 2'd2
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W:0]   size;
      logic              free;
   } entry_type;

   typedef enum logic [2:0] {
      CMD_HOLD   = 3'd0,
      CMD_LOAD   = 3'd1,
      CMD_SHIFTR = 3'd2,
      CMD_SHIFTL = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;
endpackage
`default_nettype wire

// File: rtl/core/ffha_if.sv
`default_nettype none
interface ffha_req_if;
   logic                       valid;
   logic                       ready;
   logic [ffha_pkg::KIND_W-1:0] kind;
   logic [ffha_pkg::SIZE_W-1:0] request_size;
   logic [ffha_pkg::ADDR_W-1:0] request_address;
   modport source (output valid, kind, request_size, request_address, input ready);
   modport sink (input valid, kind, request_size, request_address, output ready);
endinterface

interface ffha_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ffha_pkg::ADDR_W-1:0] result_address;
   logic [ffha_pkg::STAT_W-1:0] status;
   modport source (output valid, result_address, status, input ready);
   modport sink (input valid, result_address, status, output ready);
endinterface
`default_nettype wire

// File: rtl/core/first_fit_heap_allocator_core.sv
// First-fit heap allocator over an address-ordered chain of block cells.
// Channels: req (kind, request_size, request_address) and rsp
// (result_address, status), valid/ready; a transfer happens when both are
// high. csr_we with csr_wdata writes heap_size and rebuilds one free block;
// write only while idle.
// One request is handled at a time. A request walks the chain one cell per
// cycle, pausing on a cell for each merge. A request that needs no walk
// offers its result in the cycle after its transfer. An allocate passes
// through the first-fit walk and the split before it offers it. A
// reallocate that moves passes through the lookup, first-fit and merge
// walks, the split, freeing the old block and each merge.
// The next request is taken in the cycle after the result transfer.
// The result waits in an output register until the receiver takes it; a
// stalled receiver holds the block, and req.ready stays low meanwhile.
// Reset (synchronous, active high) restores a HEAP_BYTES_MAX heap (1 MiB by
// default) as one free block.
`default_nettype none
module first_fit_heap_allocator_core #(
   parameter int MAX_BLOCKS = 64,
   parameter int HEADER_BYTES = 24,
   parameter int HEAP_BYTES_MAX = 1048576
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ffha_req_if.sink                         req,
   ffha_rsp_if.source                       rsp,
   input  wire logic                        csr_we,
   input  wire logic [ffha_pkg::SIZE_W-1:0] csr_wdata
);
   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int AW = ffha_pkg::ADDR_W;
   localparam logic [AW:0] HDR = (AW+1)'(HEADER_BYTES);
   localparam logic [AW:0] HMAX = (AW+1)'(HEAP_BYTES_MAX);
   localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);

   typedef enum logic [3:0] {
      S_IDLE, S_LOOK, S_FIT, S_SPLIT, S_MERGE, S_OUT
   } state_type;

   ffha_pkg::entry_type cells [MAX_BLOCKS];
   ffha_pkg::cmd_type   cmds [MAX_BLOCKS];
   ffha_pkg::entry_type loads [MAX_BLOCKS];

   state_type state_ff;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] idx_ff;
   logic [IW-1:0] old_ff;
   logic          free_after_ff;
   logic [ffha_pkg::KIND_W-1:0] kind_ff;
   logic [AW:0] size_ff;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] res_ff;
   logic [ffha_pkg::STAT_W-1:0] st_ff;
   logic [AW:0]   cfg_bytes;

   ffha_pkg::entry_type cur, nxt;
   logic [CW-1:0] idx_w;
   logic [AW:0] split_rem;
   logic split_ok, look_hit, merge_now, fit_hit;

   assign cur = cells[idx_ff];
   assign nxt = cells[IW'(idx_ff + 1'b1)];
   assign idx_w = CW'(idx_ff);

   always_comb begin
      if (csr_wdata < HDR + 1'b1) cfg_bytes = HDR + 1'b1;
      else if (csr_wdata > HMAX) cfg_bytes = HMAX;
      else cfg_bytes = csr_wdata;
   end

   assign split_rem = cur.size - size_ff - HDR;
   assign split_ok = (cur.size > size_ff + HDR) && (count_ff < CMAX);
   assign look_hit = (cur.start + HDR[AW-1:0]) == addr_ff;
   assign merge_now = cur.free && nxt.free && (idx_w + 1 < count_ff);
   assign fit_hit = cur.free && (cur.size >= size_ff);

   always_comb begin
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         cmds[k] = ffha_pkg::CMD_HOLD;
         loads[k] = cells[k];
      end
      if (reset || csr_we) begin
         for (int k = 0; k < MAX_BLOCKS; k++) cmds[k] = ffha_pkg::CMD_CLEAR;
         cmds[0] = ffha_pkg::CMD_LOAD;
         loads[0].start = '0;
         loads[0].size = reset ? HMAX - HDR : cfg_bytes - HDR;
         loads[0].free = 1'b1;
      end else begin
         unique case (state_ff)
            S_SPLIT: begin
               cmds[idx_ff] = ffha_pkg::CMD_LOAD;
               loads[idx_ff].free = 1'b0;
               if (split_ok) begin
                  for (int k = 0; k < MAX_BLOCKS; k++)
                     if (k > idx_w + 1 && k <= count_ff) cmds[k] = ffha_pkg::CMD_SHIFTR;
                  loads[idx_ff].size = size_ff;
                  cmds[IW'(idx_ff + 1'b1)] = ffha_pkg::CMD_LOAD;
                  loads[IW'(idx_ff + 1'b1)].start = cur.start + HDR[AW-1:0] + size_ff[AW-1:0];
                  loads[IW'(idx_ff + 1'b1)].size = split_rem;
                  loads[IW'(idx_ff + 1'b1)].free = 1'b1;
               end
            end
            S_LOOK: begin
               if (look_hit && kind_ff == ffha_pkg::KIND_FREE) begin
                  cmds[idx_ff] = ffha_pkg::CMD_LOAD;
                  loads[idx_ff].free = 1'b1;
               end
            end
            S_MERGE: begin
               if (free_after_ff) begin
                  cmds[old_ff] = ffha_pkg::CMD_LOAD;
                  loads[old_ff].free = 1'b1;
               end else if (merge_now) begin
                  cmds[idx_ff] = ffha_pkg::CMD_LOAD;
                  loads[idx_ff].size = cur.size + HDR + nxt.size;
                  for (int k = 0; k < MAX_BLOCKS; k++)
                     if (k > idx_w && k + 1 < count_ff) cmds[k] = ffha_pkg::CMD_SHIFTL;
                  cmds[IW'(count_ff - 1'b1)] = ffha_pkg::CMD_CLEAR;
               end
            end
            default: ;
         endcase
      end
   end

   for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      ffha_cell u_cell (
         .clock(clock), .cmd(cmds[g]), .load_val(loads[g]),
         .left_val(cells[(g == 0) ? 0 : g - 1]),
         .right_val(cells[(g == MAX_BLOCKS - 1) ? g : g + 1]),
         .val(cells[g])
      );
   end

   assign req.ready = (state_ff == S_IDLE) && !csr_we;
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.result_address = res_ff;
   assign rsp.status = st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= CW'(1);
         free_after_ff <= 1'b0;
      end else if (csr_we) begin
         count_ff <= CW'(1);
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req.valid) begin
               kind_ff <= (req.kind == ffha_pkg::KIND_REALLOC && req.request_address == '0)
                          ? ffha_pkg::KIND_ALLOC : req.kind;
               size_ff <= req.request_size;
               addr_ff <= req.request_address;
               res_ff <= '0;
               st_ff <= ffha_pkg::ST_DONE;
               idx_ff <= '0;
               free_after_ff <= 1'b0;
               if (req.kind == ffha_pkg::KIND_NONE) state_ff <= S_OUT;
               else if (req.kind == ffha_pkg::KIND_FREE && req.request_address == '0)
                  state_ff <= S_OUT;
               else if ((req.kind == ffha_pkg::KIND_ALLOC ||
                         (req.kind == ffha_pkg::KIND_REALLOC && req.request_address == '0))
                        && req.request_size == '0)
                  state_ff <= S_OUT;
               else if (req.kind == ffha_pkg::KIND_ALLOC || req.request_address == '0)
                  state_ff <= S_FIT;
               else state_ff <= S_LOOK;
            end
            S_LOOK: begin
               if (look_hit) begin
                  if (kind_ff == ffha_pkg::KIND_FREE) begin
                     idx_ff <= '0;
                     state_ff <= S_MERGE;
                  end else if (cur.free) begin
                     st_ff <= ffha_pkg::ST_BADADDR;
                     state_ff <= S_OUT;
                  end else if (cur.size >= size_ff) begin
                     res_ff <= addr_ff;
                     state_ff <= S_OUT;
                  end else begin
                     old_ff <= idx_ff;
                     idx_ff <= '0;
                     state_ff <= S_FIT;
                  end
               end else if (idx_w + 1 >= count_ff) begin
                  st_ff <= ffha_pkg::ST_BADADDR;
                  state_ff <= S_OUT;
               end else idx_ff <= idx_ff + 1'b1;
            end
            S_FIT: begin
               if (fit_hit) state_ff <= S_SPLIT;
               else if (idx_w + 1 >= count_ff) begin
                  st_ff <= ffha_pkg::ST_NOFIT;
                  state_ff <= S_OUT;
               end else idx_ff <= idx_ff + 1'b1;
            end
            S_SPLIT: begin
               res_ff <= cur.start + HDR[AW-1:0];
               if (split_ok) begin
                  count_ff <= count_ff + 1'b1;
                  if (kind_ff == ffha_pkg::KIND_REALLOC && old_ff > idx_ff)
                     old_ff <= old_ff + 1'b1;
               end
               if (kind_ff == ffha_pkg::KIND_REALLOC) begin
                  free_after_ff <= 1'b1;
                  state_ff <= S_MERGE;
               end else state_ff <= S_OUT;
               idx_ff <= '0;
            end
            S_MERGE: begin
               if (free_after_ff) begin
                  free_after_ff <= 1'b0;
               end else if (merge_now) count_ff <= count_ff - 1'b1;
               else if (idx_w + 1 >= count_ff) state_ff <= S_OUT;
               else idx_ff <= idx_ff + 1'b1;
            end
            S_OUT: if (rsp.ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CMAX) else $error("block count out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset || csr_we)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_address))
      else $error("result changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("accepting while result pending");
`endif
endmodule
`default_nettype wire

// File: rtl/core/ffha_cell.sv
`default_nettype none
module ffha_cell (
   input  wire logic                clock,
   input  wire ffha_pkg::cmd_type   cmd,
   input  wire ffha_pkg::entry_type load_val,
   input  wire ffha_pkg::entry_type left_val,
   input  wire ffha_pkg::entry_type right_val,
   output ffha_pkg::entry_type      val
);
   ffha_pkg::entry_type val_ff, val_in;

   always_comb begin
      val_in = val_ff;
      unique case (cmd)
         ffha_pkg::CMD_HOLD:   val_in = val_ff;
         ffha_pkg::CMD_LOAD:   val_in = load_val;
         ffha_pkg::CMD_SHIFTR: val_in = left_val;
         ffha_pkg::CMD_SHIFTL: val_in = right_val;
         ffha_pkg::CMD_CLEAR:  val_in = '0;
         default:              val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;
endmodule
`default_nettype wire
